>>> src/reliable_receive_reorder_window_unit_assert.svh
// assertion macros for the reorder window unit
// the using scope must provide clk and arst_n
`ifndef RELIABLE_RECEIVE_REORDER_WINDOW_UNIT_ASSERT_SVH
`define RELIABLE_RECEIVE_REORDER_WINDOW_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RRRW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("reorder window assertion failed");

// consequent must hold in the cycle after the antecedent
`define RRRW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("reorder window assertion failed");

`endif

>>> src/rrrw_pkg.sv
// shared types and codes of the reorder window unit
// no dependencies
`default_nettype none

package rrrw_pkg;

	localparam int ID_W        = 32;
	localparam int BYTE_W      = 8;
	localparam int STATUS_W    = 3;
	localparam int MAX_RESULTS = 64;
	localparam int BURST_W     = $clog2(MAX_RESULTS);
	localparam int IN_DATA_W   = 40;
	localparam int IN_USER_W   = 2;
	localparam int OUT_DATA_W  = 16;
	localparam int OUT_USER_W  = 3;

	// result kinds
	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ABSENT = 2'd2
	} kind_t;

	// status codes of a write result
	localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OLD    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BEYOND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUP    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TRUNC  = 3'd4;
	// status of a data result
	localparam logic [STATUS_W-1:0] ST_MORE    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MSG_END = 3'd1;

	// per-message write phase
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_STORE  = 3'd1,
		PH_OLD    = 3'd2,
		PH_BEYOND = 3'd3,
		PH_DUP    = 3'd4
	} wr_phase_t;

	// controller states
	typedef enum logic [1:0] {
		CS_IDLE = 2'd0,
		CS_LEN  = 2'd1,
		CS_EMIT = 2'd2
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic wr_item;
		logic len_rd;
		logic absent;
		logic end_mark;
		logic burst_start;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic in_read;
		logic out_busy;
		logic out_free;
		logic slot_hit;
		logic none_left;
		logic burst_last;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> src/reliable_receive_reorder_window_unit.sv
// write item: one per cycle while the output register is empty; a status result is valid in the
// cycle after the last item's transfer
// read item: slot length read, then memory read, then one byte per cycle while the receiver takes
// them; an absent or empty message is answered after the length read; a new item is taken once the
// controller is idle and the output register is empty, in the cycle after the last result's transfer
// reset (arst_n low, asynchronous) clears the slot valid bits, sets the expected id to one, idles writes
`default_nettype none

`include "reliable_receive_reorder_window_unit_assert.svh"

module reliable_receive_reorder_window_unit #(
	parameter int WINDOW_SLOTS = 64,
	parameter int MAX_BYTES    = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // msg_id[31:0], data_byte[39:32]
	input  wire logic [1:0]  s_axis_tuser,  // mode[0], byte_valid[1]
	input  wire logic        s_axis_tlast,  // last_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // status[2:0], out_byte[10:3], zero[15:11]
	output logic      [2:0]  m_axis_tuser,  // result_kind[1:0], out_byte_valid[2]
	output logic             m_axis_tlast   // last_out
);

	rrrw_pkg::ctrl_cmd_t cmd;
	rrrw_pkg::dp_stat_t  stat;

	// controller
	rrrw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// datapath
	rrrw_dpath #(
		.WINDOW_SLOTS (WINDOW_SLOTS),
		.MAX_BYTES    (MAX_BYTES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_tvalid  (s_axis_tvalid),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.in_tlast   (s_axis_tlast),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.out_tlast  (m_axis_tlast)
	);

	assign s_axis_tready = cmd.in_ready;

	// input side only opens with an empty output register
	`RRRW_ASSERT_NOW(a_ready_needs_empty_out, s_axis_tready, !m_axis_tvalid)

	// a read transfer is always answered by the length step in the next cycle
	`RRRW_ASSERT_NEXT(a_read_then_len_step, s_axis_tvalid && s_axis_tready && s_axis_tuser[0],
		cmd.absent || cmd.end_mark || cmd.burst_start)

	// an absent message gives a single closing result without a byte
	`RRRW_ASSERT_NOW(a_absent_single, m_axis_tvalid && (m_axis_tuser[1:0] == rrrw_pkg::KIND_ABSENT),
		m_axis_tlast && !m_axis_tuser[2])

endmodule

`default_nettype wire

>>> src/rrrw_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module rrrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> src/rrrw_ctrl.sv
// controller state machine of the reorder window unit
// depends on rrrw_pkg
`default_nettype none

module rrrw_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rrrw_pkg::dp_stat_t   stat,
	output rrrw_pkg::ctrl_cmd_t       cmd
);

	rrrw_pkg::ctrl_state_t state_q;
	rrrw_pkg::ctrl_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrrw_pkg::CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rrrw_pkg::CS_IDLE: begin
				if (stat.in_valid && !stat.out_busy && stat.in_read) begin
					state_nxt = rrrw_pkg::CS_LEN;
				end
			end
			rrrw_pkg::CS_LEN: begin
				if (stat.slot_hit && !stat.none_left) begin
					state_nxt = rrrw_pkg::CS_EMIT;
				end else begin
					state_nxt = rrrw_pkg::CS_IDLE;
				end
			end
			rrrw_pkg::CS_EMIT: begin
				if (stat.out_free && stat.burst_last) begin
					state_nxt = rrrw_pkg::CS_IDLE;
				end
			end
			default: begin
				state_nxt = rrrw_pkg::CS_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			rrrw_pkg::CS_IDLE: begin
				cmd.in_ready = !stat.out_busy;
				if (stat.in_valid && !stat.out_busy) begin
					cmd.len_rd  = stat.in_read;
					cmd.wr_item = !stat.in_read;
				end
			end
			rrrw_pkg::CS_LEN: begin
				if (!stat.slot_hit) begin
					cmd.absent = 1'b1;
				end else if (stat.none_left) begin
					cmd.end_mark = 1'b1;
				end else begin
					cmd.burst_start = 1'b1;
				end
			end
			rrrw_pkg::CS_EMIT: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/rrrw_dpath.sv
// datapath of the reorder window unit: window state, stores, output register
// depends on rrrw_pkg and rrrw_ram
`default_nettype none

module rrrw_dpath #(
	parameter int WINDOW_SLOTS = 64,
	parameter int MAX_BYTES    = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire rrrw_pkg::ctrl_cmd_t                    cmd,
	output rrrw_pkg::dp_stat_t                          stat,
	input  wire logic                                   in_tvalid,
	input  wire logic [rrrw_pkg::IN_DATA_W-1:0]         in_tdata,
	input  wire logic [rrrw_pkg::IN_USER_W-1:0]         in_tuser,
	input  wire logic                                   in_tlast,
	input  wire logic                                   out_tready,
	output logic                                        out_tvalid,
	output logic      [rrrw_pkg::OUT_DATA_W-1:0]        out_tdata,
	output logic      [rrrw_pkg::OUT_USER_W-1:0]        out_tuser,
	output logic                                        out_tlast
);

	localparam int SLOT_W = $clog2(WINDOW_SLOTS);
	localparam int LEN_W  = $clog2(MAX_BYTES + 1);
	localparam int CNT_W  = $clog2(MAX_BYTES + 2);
	localparam int DEPTH  = WINDOW_SLOTS * MAX_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [SLOT_W-1:0]           LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
	localparam logic [SLOT_W:0]             WIN_SUM   = (SLOT_W + 1)'(WINDOW_SLOTS);
	localparam logic [rrrw_pkg::ID_W-1:0]   WIN_ID    = rrrw_pkg::ID_W'(WINDOW_SLOTS);
	localparam logic [CNT_W-1:0]            MAX_CNT   = CNT_W'(MAX_BYTES);
	localparam logic [CNT_W-1:0]            OVF_CNT   = CNT_W'(MAX_BYTES + 1);
	localparam logic [ADDR_W-1:0]           MAX_ADDR  = ADDR_W'(MAX_BYTES);
	localparam logic [rrrw_pkg::BURST_W-1:0] BURST_END =
		rrrw_pkg::BURST_W'(rrrw_pkg::MAX_RESULTS - 1);

	// input fields
	logic [rrrw_pkg::ID_W-1:0]   in_id;
	logic [rrrw_pkg::BYTE_W-1:0] in_byte;
	logic                        in_read;
	logic                        in_bv;

	assign in_id   = in_tdata[31:0];
	assign in_byte = in_tdata[39:32];
	assign in_read = in_tuser[0];
	assign in_bv   = in_tuser[1];

	// window state
	logic [rrrw_pkg::ID_W-1:0] exp_id_q;
	logic [SLOT_W-1:0]         exp_slot_q;
	logic [WINDOW_SLOTS-1:0]   valid_q;
	rrrw_pkg::wr_phase_t       ph_q;
	logic [SLOT_W-1:0]         wslot_q;
	logic [CNT_W-1:0]          wcnt_q;
	logic [LEN_W-1:0]          off_q;

	// read burst state
	logic [LEN_W-1:0]             len_q;
	logic [LEN_W-1:0]             pos_q;
	logic [rrrw_pkg::BURST_W-1:0] bcnt_q;

	// output register
	logic                            out_valid_q;
	rrrw_pkg::kind_t                 out_kind_q;
	logic [rrrw_pkg::STATUS_W-1:0]   out_status_q;
	logic [rrrw_pkg::BYTE_W-1:0]     out_byte_q;
	logic                            out_bv_q;
	logic                            out_last_q;

	// verdict on the first item of a message
	logic [rrrw_pkg::ID_W-1:0] diff;
	logic [SLOT_W-1:0]         diff_s;
	logic [SLOT_W:0]           slot_sum;
	logic [SLOT_W:0]           slot_wrap;
	logic [SLOT_W-1:0]         new_idx;
	logic                      is_old;
	logic                      is_beyond;
	rrrw_pkg::wr_phase_t       verdict;

	assign diff      = in_id - exp_id_q;
	assign diff_s    = diff[SLOT_W-1:0];
	assign is_old    = in_id < exp_id_q;
	assign is_beyond = diff >= WIN_ID;
	assign slot_sum  = {1'b0, exp_slot_q} + {1'b0, diff_s};
	assign slot_wrap = (slot_sum >= WIN_SUM) ? slot_sum - WIN_SUM : slot_sum;

	// slot of an id in the window; id zero sits below id one across the wrap
	always_comb begin
		if ((exp_id_q == '0) && (diff_s != '0)) begin
			new_idx = diff_s - 1'b1;
		end else begin
			new_idx = slot_wrap[SLOT_W-1:0];
		end
	end

	always_comb begin
		if (is_old) begin
			verdict = rrrw_pkg::PH_OLD;
		end else if (is_beyond) begin
			verdict = rrrw_pkg::PH_BEYOND;
		end else if (valid_q[new_idx]) begin
			verdict = rrrw_pkg::PH_DUP;
		end else begin
			verdict = rrrw_pkg::PH_STORE;
		end
	end

	// effective write state for the current item
	logic                      first_item;
	logic                      new_store;
	rrrw_pkg::wr_phase_t       ph_eff;
	logic [SLOT_W-1:0]         slot_eff;
	logic [CNT_W-1:0]          cnt_eff;
	logic                      take_byte;
	logic                      room;
	logic [CNT_W-1:0]          cnt_new;
	logic                      finish;
	logic [LEN_W-1:0]          store_len;
	logic [rrrw_pkg::STATUS_W-1:0] wr_status;

	assign first_item = ph_q == rrrw_pkg::PH_IDLE;
	assign new_store  = first_item && (verdict == rrrw_pkg::PH_STORE);
	assign ph_eff     = first_item ? verdict : ph_q;
	assign slot_eff   = new_store ? new_idx : wslot_q;
	assign cnt_eff    = new_store ? '0 : wcnt_q;
	assign take_byte  = (ph_eff == rrrw_pkg::PH_STORE) && in_bv;
	assign room       = cnt_eff < MAX_CNT;
	assign finish     = cmd.wr_item && in_tlast;
	assign store_len  = (cnt_new > MAX_CNT) ? LEN_W'(MAX_BYTES) : LEN_W'(cnt_new);

	always_comb begin
		cnt_new = cnt_eff;
		if (take_byte) begin
			cnt_new = room ? cnt_eff + 1'b1 : OVF_CNT;
		end
	end

	always_comb begin
		case (ph_eff)
			rrrw_pkg::PH_OLD:    wr_status = rrrw_pkg::ST_OLD;
			rrrw_pkg::PH_BEYOND: wr_status = rrrw_pkg::ST_BEYOND;
			rrrw_pkg::PH_DUP:    wr_status = rrrw_pkg::ST_DUP;
			default: begin
				wr_status = (cnt_new > MAX_CNT) ? rrrw_pkg::ST_TRUNC : rrrw_pkg::ST_STORED;
			end
		endcase
	end

	// message byte store
	logic                      mem_we;
	logic [ADDR_W-1:0]         mem_waddr;
	logic                      mem_re;
	logic [ADDR_W-1:0]         mem_raddr;
	logic [rrrw_pkg::BYTE_W-1:0] mem_rdata;
	logic [ADDR_W-1:0]         exp_base;
	logic [LEN_W-1:0]          pos_nxt;

	assign mem_we    = cmd.wr_item && take_byte && room;
	assign mem_waddr = ADDR_W'(slot_eff) * MAX_ADDR + ADDR_W'(cnt_eff);
	assign exp_base  = ADDR_W'(exp_slot_q) * MAX_ADDR;
	assign pos_nxt   = pos_q + 1'b1;

	// read burst progress
	logic ends;
	logic burst_last;

	assign ends       = pos_nxt == len_q;
	assign burst_last = ends || (bcnt_q == BURST_END);
	assign mem_re     = cmd.burst_start || (cmd.emit && !burst_last);
	assign mem_raddr  = exp_base + ADDR_W'(cmd.burst_start ? off_q : pos_nxt);

	rrrw_ram #(
		.WIDTH (rrrw_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_msg_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (in_byte),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// slot length store
	logic [LEN_W-1:0] len_rdata;

	rrrw_ram #(
		.WIDTH (LEN_W),
		.DEPTH (WINDOW_SLOTS)
	) u_len_ram (
		.clk     (clk),
		.wr_en   (finish && (ph_eff == rrrw_pkg::PH_STORE)),
		.wr_addr (slot_eff),
		.wr_data (store_len),
		.rd_en   (cmd.len_rd),
		.rd_addr (exp_slot_q),
		.rd_data (len_rdata)
	);

	// expected message retires on its final byte or end marker
	logic free_slot;

	assign free_slot = cmd.end_mark || (cmd.emit && ends);

	// window and write state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q   <= rrrw_pkg::ID_W'(1);
			exp_slot_q <= '0;
			valid_q    <= '0;
			ph_q       <= rrrw_pkg::PH_IDLE;
			wslot_q    <= '0;
			wcnt_q     <= '0;
			off_q      <= '0;
		end else begin
			if (cmd.wr_item) begin
				if (in_tlast) begin
					ph_q   <= rrrw_pkg::PH_IDLE;
					wcnt_q <= '0;
					if (ph_eff == rrrw_pkg::PH_STORE) begin
						valid_q[slot_eff] <= 1'b1;
					end
				end else begin
					ph_q    <= ph_eff;
					wslot_q <= slot_eff;
					wcnt_q  <= cnt_new;
				end
			end
			if (free_slot) begin
				valid_q[exp_slot_q] <= 1'b0;
				exp_id_q            <= exp_id_q + 1'b1;
				off_q               <= '0;
				if ((exp_id_q == '0) || (exp_slot_q == LAST_SLOT)) begin
					exp_slot_q <= '0;
				end else begin
					exp_slot_q <= exp_slot_q + 1'b1;
				end
			end else if (cmd.emit && burst_last) begin
				off_q <= pos_nxt;
			end
		end
	end

	// burst position and count
	always_ff @(posedge clk) begin
		if (cmd.burst_start) begin
			len_q  <= len_rdata;
			pos_q  <= off_q;
			bcnt_q <= '0;
		end else if (cmd.emit && !burst_last) begin
			pos_q  <= pos_nxt;
			bcnt_q <= bcnt_q + 1'b1;
		end
	end

	// output register valid
	logic out_load;

	assign out_load = finish || cmd.absent || cmd.end_mark || cmd.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q   <= rrrw_pkg::KIND_DATA;
			out_status_q <= ends ? rrrw_pkg::ST_MSG_END : rrrw_pkg::ST_MORE;
			out_byte_q   <= mem_rdata;
			out_bv_q     <= 1'b1;
			out_last_q   <= burst_last;
		end else if (cmd.end_mark) begin
			out_kind_q   <= rrrw_pkg::KIND_DATA;
			out_status_q <= rrrw_pkg::ST_MSG_END;
			out_byte_q   <= '0;
			out_bv_q     <= 1'b0;
			out_last_q   <= 1'b1;
		end else if (cmd.absent) begin
			out_kind_q   <= rrrw_pkg::KIND_ABSENT;
			out_status_q <= rrrw_pkg::ST_STORED;
			out_byte_q   <= '0;
			out_bv_q     <= 1'b0;
			out_last_q   <= 1'b1;
		end else if (finish) begin
			out_kind_q   <= rrrw_pkg::KIND_STATUS;
			out_status_q <= wr_status;
			out_byte_q   <= '0;
			out_bv_q     <= 1'b0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {5'b0, out_byte_q, out_status_q};
	assign out_tuser  = {out_bv_q, out_kind_q};
	assign out_tlast  = out_last_q;

	// status to the controller
	assign stat.in_valid   = in_tvalid;
	assign stat.in_read    = in_read;
	assign stat.out_busy   = out_valid_q;
	assign stat.out_free   = !out_valid_q || out_tready;
	assign stat.slot_hit   = valid_q[exp_slot_q];
	assign stat.none_left  = off_q >= len_rdata;
	assign stat.burst_last = burst_last;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for reliable_receive_reorder_window_unit: write and read transfers
// are checked against a local copy of the reorder window; needs rrrw_pkg and the unit's rtl

module testbench;

	localparam int WINDOW_SLOTS = 64;
	localparam int MAX_BYTES    = 256;
	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 6;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 12;
	localparam int TAIL_CYCLES  = 20;
	localparam int NUM_PHASES   = 4;

	// status field of results that carry no status
	localparam logic [rrrw_pkg::STATUS_W-1:0] ST_NONE = '0;

	typedef struct packed {
		rrrw_pkg::kind_t               kind;
		logic [rrrw_pkg::STATUS_W-1:0] status;
		logic [rrrw_pkg::BYTE_W-1:0]   data;
		logic                          data_valid;
		logic                          last;
	} result_t;

	typedef struct packed {
		logic                        mode;
		logic [rrrw_pkg::ID_W-1:0]   id;
		logic [rrrw_pkg::BYTE_W-1:0] data;
		logic                        data_valid;
		logic                        last;
		logic                        given;   // row carries its own expected result
		result_t                     want;
	} item_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [rrrw_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // msg_id[31:0], data_byte[39:32]
	logic [rrrw_pkg::IN_USER_W-1:0]  s_axis_tuser;   // mode[0], byte_valid[1]
	logic                            s_axis_tlast;   // last_in
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [rrrw_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // status[2:0], out_byte[10:3], zero[15:11]
	logic [rrrw_pkg::OUT_USER_W-1:0] m_axis_tuser;   // result_kind[1:0], out_byte_valid[2]
	logic                            m_axis_tlast;   // last_out

	reliable_receive_reorder_window_unit #(
		.WINDOW_SLOTS(WINDOW_SLOTS),
		.MAX_BYTES   (MAX_BYTES)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// window copy
	logic [rrrw_pkg::BYTE_W-1:0] msg_mem [WINDOW_SLOTS][MAX_BYTES];
	int unsigned                 slot_len [WINDOW_SLOTS];
	logic                        slot_full [WINDOW_SLOTS];
	logic [rrrw_pkg::ID_W-1:0]   next_id;
	rrrw_pkg::wr_phase_t         wr_phase;
	int unsigned                 wr_slot;
	int unsigned                 wr_count;
	int unsigned                 rd_offset;
	result_t                     pending_results [$];

	item_t       cur_item;
	result_t     head;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned hold_left;
	int unsigned items_sent;
	int unsigned quiet;
	int unsigned errors;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void push_result(rrrw_pkg::kind_t kind,
			logic [rrrw_pkg::STATUS_W-1:0] st, logic [rrrw_pkg::BYTE_W-1:0] data,
			logic dv, logic last);
		result_t r;
		r.kind       = kind;
		r.status     = st;
		r.data       = data;
		r.data_valid = dv;
		r.last       = last;
		pending_results.push_back(r);
	endfunction

	// advance the window by one accepted item and queue the results it causes
	function automatic void window_accept(item_t it);
		logic [rrrw_pkg::ID_W-1:0]     adj;
		logic [rrrw_pkg::ID_W-1:0]     gap;
		int unsigned                   idx;
		int unsigned                   n;
		logic [rrrw_pkg::STATUS_W-1:0] st;
		if (it.mode) begin
			adj = next_id - 1'b1;
			idx = adj % WINDOW_SLOTS;
			if (!slot_full[idx]) begin
				push_result(rrrw_pkg::KIND_ABSENT, ST_NONE, '0, 1'b0, 1'b1);
				return;
			end
			n = (rd_offset >= slot_len[idx]) ? 0 : slot_len[idx] - rd_offset;
			if (n > rrrw_pkg::MAX_RESULTS)
				n = rrrw_pkg::MAX_RESULTS;
			// empty message or nothing left: a lone end marker
			if (n == 0)
				push_result(rrrw_pkg::KIND_DATA, rrrw_pkg::ST_MSG_END, '0, 1'b0, 1'b1);
			for (int unsigned i = 0; i < n; i++)
				push_result(rrrw_pkg::KIND_DATA,
					(rd_offset + i + 1 == slot_len[idx]) ? rrrw_pkg::ST_MSG_END
						: rrrw_pkg::ST_MORE,
					msg_mem[idx][rd_offset + i], 1'b1, i + 1 == n);
			rd_offset += n;
			if (rd_offset >= slot_len[idx]) begin
				slot_full[idx] = 1'b0;
				next_id        = next_id + 1'b1;
				rd_offset      = 0;
			end
			return;
		end

		// verdict on the first item of a message
		if (wr_phase == rrrw_pkg::PH_IDLE) begin
			adj = it.id - 1'b1;
			idx = adj % WINDOW_SLOTS;
			gap = it.id - next_id;
			if (it.id < next_id)
				wr_phase = rrrw_pkg::PH_OLD;
			else if (gap >= WINDOW_SLOTS)
				wr_phase = rrrw_pkg::PH_BEYOND;
			else if (slot_full[idx])
				wr_phase = rrrw_pkg::PH_DUP;
			else begin
				wr_phase = rrrw_pkg::PH_STORE;
				wr_slot  = idx;
				wr_count = 0;
			end
		end

		// bytes past the limit only mark the overflow
		if (wr_phase == rrrw_pkg::PH_STORE && it.data_valid) begin
			if (wr_count < MAX_BYTES) begin
				msg_mem[wr_slot][wr_count] = it.data;
				wr_count++;
			end else
				wr_count = MAX_BYTES + 1;
		end

		if (!it.last)
			return;
		case (wr_phase)
			rrrw_pkg::PH_OLD:    st = rrrw_pkg::ST_OLD;
			rrrw_pkg::PH_BEYOND: st = rrrw_pkg::ST_BEYOND;
			rrrw_pkg::PH_DUP:    st = rrrw_pkg::ST_DUP;
			default: begin
				st                 = (wr_count > MAX_BYTES) ? rrrw_pkg::ST_TRUNC
					: rrrw_pkg::ST_STORED;
				slot_len[wr_slot]  = (wr_count > MAX_BYTES) ? MAX_BYTES : wr_count;
				slot_full[wr_slot] = 1'b1;
			end
		endcase
		wr_phase = rrrw_pkg::PH_IDLE;
		wr_count = 0;
		push_result(rrrw_pkg::KIND_STATUS, st, '0, 1'b0, 1'b1);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// result checking, model update on input transfers, idle watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual tdata %h tuser %h tlast %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					head = pending_results.pop_front();
					check_field("result_kind", head.kind, m_axis_tuser[1:0]);
					check_field("status", head.status, m_axis_tdata[2:0]);
					check_field("out_byte", head.data, m_axis_tdata[10:3]);
					check_field("out_byte_valid", head.data_valid, m_axis_tuser[2]);
					check_field("last_out", head.last, m_axis_tlast);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				window_accept(cur_item);
				// a row with its own answer still moves the window on
				if (cur_item.given) begin
					void'(pending_results.pop_back());
					pending_results.push_back(cur_item.want);
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else begin
				quiet++;
				if (quiet >= STALL_LIMIT) begin
					$display("testbench: errors");
					$finish;
				end
			end
		end
	end

	// receiver: long hold-off when asked, otherwise random stalls
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else
				m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// offer one item from a falling edge and return at the falling edge after its transfer
	task automatic send_item(item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		cur_item      = it;
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {it.data, it.id};
		s_axis_tuser  = {it.data_valid, it.mode};
		s_axis_tlast  = it.last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [rrrw_pkg::BYTE_W-1:0] rand_byte();
		logic [31:0] r;
		r = $urandom();
		return r[rrrw_pkg::BYTE_W-1:0];
	endfunction

	function automatic item_t row(logic mode, logic [rrrw_pkg::ID_W-1:0] id,
			logic [rrrw_pkg::BYTE_W-1:0] data, logic dv, logic last);
		item_t it;
		it            = '0;
		it.mode       = mode;
		it.id         = id;
		it.data       = data;
		it.data_valid = dv;
		it.last       = last;
		return it;
	endfunction

	function automatic item_t row_given(logic mode, logic [rrrw_pkg::ID_W-1:0] id,
			logic [rrrw_pkg::BYTE_W-1:0] data, logic dv, logic last, rrrw_pkg::kind_t kind,
			logic [rrrw_pkg::STATUS_W-1:0] st);
		item_t it;
		it                 = row(mode, id, data, dv, last);
		it.given           = 1'b1;
		it.want.kind       = kind;
		it.want.status     = st;
		it.want.data       = '0;
		it.want.data_valid = 1'b0;
		it.want.last       = 1'b1;
		return it;
	endfunction

	// read request with random content in the ignored fields
	function automatic item_t read_item();
		return row(1'b1, $urandom(), rand_byte(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endfunction

	// one message of n bytes, with stray byteless items and reads mixed in
	task automatic write_message(logic [rrrw_pkg::ID_W-1:0] id, int unsigned n);
		item_t it;
		bit    opening;
		opening = 1'b1;
		if (n == 0) begin
			send_item(row(1'b0, id, rand_byte(), 1'b0, 1'b1));
			return;
		end
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 24) == 0)
				send_item(read_item());
			if ($urandom_range(0, 12) == 0) begin
				send_item(row(1'b0, opening ? id : $urandom(), rand_byte(), 1'b0, 1'b0));
				opening = 1'b0;
			end
			it = row(1'b0, opening ? id : $urandom(), rand_byte(), 1'b1, i == n - 1);
			// now and then the closing item carries no byte
			if (it.last && $urandom_range(0, 15) == 0)
				it.data_valid = 1'b0;
			send_item(it);
			opening = 1'b0;
		end
	endtask

	// mostly in-window messages and reads, some stale and wild ids
	task automatic random_action();
		int unsigned               pick;
		int unsigned               len_pick;
		int unsigned               len;
		logic [rrrw_pkg::ID_W-1:0] id;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			send_item(read_item());
			return;
		end
		if (pick < 85)
			id = next_id + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 70)
				: $urandom_range(0, 3));
		else if (pick < 93)
			id = next_id - $urandom_range(1, 4);
		else
			id = $urandom();
		len_pick = $urandom_range(0, 99);
		if (len_pick < 10)
			len = 0;
		else if (len_pick < 95)
			len = $urandom_range(1, 8);
		else
			len = $urandom_range(60, 70);
		write_message(id, len);
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	initial begin
		item_t       rows [$];
		int unsigned phase_start;
		int unsigned phase_idle [NUM_PHASES];
		int unsigned phase_stall [NUM_PHASES];
		phase_idle  = '{0, 85, 0, 9};
		phase_stall = '{0, 0, 85, 9};

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		cur_item      = '0;
		idle_pct      = 0;
		stall_pct     = 0;
		hold_left     = 0;
		items_sent    = 0;
		quiet         = 0;
		errors        = 0;
		for (int i = 0; i < WINDOW_SLOTS; i++)
			slot_full[i] = 1'b0;
		next_id   = 1;
		wr_phase  = rrrw_pkg::PH_IDLE;
		wr_slot   = 0;
		wr_count  = 0;
		rd_offset = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed rows: reset state, id extremes, window edges, empty and interleaved
		rows.push_back(row_given(1'b1, $urandom(), rand_byte(), 1'b0, 1'b0,
			rrrw_pkg::KIND_ABSENT, ST_NONE));
		rows.push_back(row(1'b0, 32'd1, 8'h00, 1'b1, 1'b0));
		rows.push_back(row_given(1'b0, $urandom(), 8'hff, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_STORED));
		rows.push_back(row_given(1'b0, 32'd1, 8'h5a, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_DUP));
		rows.push_back(row_given(1'b0, 32'd0, 8'h00, 1'b0, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_OLD));
		rows.push_back(row_given(1'b0, 32'hffff_ffff, 8'h00, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_BEYOND));
		rows.push_back(row_given(1'b0, 32'd65, 8'h11, 1'b0, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_BEYOND));
		rows.push_back(row_given(1'b0, 32'd64, 8'ha5, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_STORED));
		rows.push_back(row(1'b1, $urandom(), rand_byte(), 1'b1, 1'b1));
		rows.push_back(row_given(1'b0, 32'd2, 8'h00, 1'b0, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_STORED));
		rows.push_back(row_given(1'b1, $urandom(), rand_byte(), 1'b1, 1'b0,
			rrrw_pkg::KIND_DATA, rrrw_pkg::ST_MSG_END));
		rows.push_back(row_given(1'b1, $urandom(), rand_byte(), 1'b0, 1'b1,
			rrrw_pkg::KIND_ABSENT, ST_NONE));
		rows.push_back(row(1'b0, 32'd3, 8'h3c, 1'b1, 1'b0));
		rows.push_back(row(1'b0, $urandom(), 8'h77, 1'b0, 1'b0));
		rows.push_back(row_given(1'b1, $urandom(), rand_byte(), 1'b0, 1'b0,
			rrrw_pkg::KIND_ABSENT, ST_NONE));
		rows.push_back(row_given(1'b0, $urandom(), 8'hc3, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_STORED));
		rows.push_back(row(1'b0, 32'd2, 8'h01, 1'b1, 1'b0));
		rows.push_back(row(1'b0, $urandom(), 8'h02, 1'b1, 1'b0));
		rows.push_back(row_given(1'b0, $urandom(), 8'h03, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_OLD));
		rows.push_back(row(1'b1, $urandom(), rand_byte(), 1'b0, 1'b0));
		rows.push_back(row_given(1'b0, 32'd66, 8'h42, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_STORED));
		rows.push_back(row_given(1'b0, 32'd67, 8'h43, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_STORED));
		rows.push_back(row_given(1'b0, 32'd68, 8'h44, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_BEYOND));
		rows.push_back(row_given(1'b0, 32'd4, 8'h80, 1'b1, 1'b1,
			rrrw_pkg::KIND_STATUS, rrrw_pkg::ST_STORED));
		rows.push_back(row(1'b1, $urandom(), rand_byte(), 1'b1, 1'b0));
		foreach (rows[i])
			send_item(rows[i]);

		// overlong message, then read it back in bursts
		write_message(next_id, MAX_BYTES + 2);
		repeat (6) send_item(read_item());
		drain();

		// random phases with different mixes of idling and receiver stalls; the first opens with a long receiver hold
		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			if (p == 0)
				hold_left = HOLD_CYCLES;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				random_action();
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/rrrw_pkg.sv
src/rrrw_ram.sv
src/rrrw_ctrl.sv
src/rrrw_dpath.sv
src/reliable_receive_reorder_window_unit.sv
dv/testbench.sv
